// File: rtl/core/trle_pkg.sv
package trle_pkg;

    // Field widths fixed by the stream format
    localparam int FIELD_BITS   = 16;
    localparam int TDATA_BITS   = 3 * FIELD_BITS;

    // Threshold registers
    localparam int THRESH_BITS  = 16;
    localparam logic [THRESH_BITS-1:0] LOW_THRESH_RESET  = 16'd1;
    localparam logic [THRESH_BITS-1:0] HIGH_THRESH_RESET = 16'hFFFF;

    // Run length counter, saturating
    localparam int LEN_BITS     = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = 16'hFFFF;

    // Parameter defaults
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int PIXEL_BITS_DEFAULT = 16;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOW_THRESH  = 1'b0,
        CFG_HIGH_THRESH = 1'b1
    } cfg_reg_t;

    // Handshake between the input register and the run core
    typedef struct packed {
        logic valid;
        logic last;
    } pix_ctrl_t;

endpackage

// File: rtl/core/trle_in_reg.sv
module trle_in_reg
    import trle_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // upstream side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_BITS-1:0] in_value,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic                  in_last,
    // toward the run core
    output pix_ctrl_t             pix_ctrl,
    input  logic                  pix_ready,
    output logic [PIXEL_BITS-1:0] pix_value,
    output logic [COORD_BITS-1:0] pix_x,
    output logic [COORD_BITS-1:0] pix_y
);

    logic                  valid_reg;
    logic                  last_reg;
    logic [PIXEL_BITS-1:0] value_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;

    // slot is free when empty or drained this cycle
    assign in_ready = !valid_reg || pix_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            last_reg  <= in_last;
            value_reg <= in_value;
            x_reg     <= in_x;
            y_reg     <= in_y;
        end
    end

    assign pix_ctrl.valid = valid_reg;
    assign pix_ctrl.last  = last_reg;
    assign pix_value      = value_reg;
    assign pix_x          = x_reg;
    assign pix_y          = y_reg;

endmodule

// File: rtl/core/trle_run_core.sv
module trle_run_core
    import trle_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // threshold writes
    input  logic                    cfg_wen,
    input  cfg_reg_t                cfg_index,
    input  logic [THRESH_BITS-1:0]  cfg_wdata,
    // registered pixel
    input  pix_ctrl_t               pix_ctrl,
    output logic                    pix_ready,
    input  logic [PIXEL_BITS-1:0]   pix_value,
    input  logic [COORD_BITS-1:0]   pix_x,
    input  logic [COORD_BITS-1:0]   pix_y,
    // finished runs
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COORD_BITS-1:0]   out_x,
    output logic [COORD_BITS-1:0]   out_y,
    output logic [LEN_BITS-1:0]     out_length
);

    logic [THRESH_BITS-1:0] low_thresh_reg;
    logic [THRESH_BITS-1:0] high_thresh_reg;

    logic                   run_open_reg, run_open_next;
    logic [COORD_BITS-1:0]  start_x_reg, start_x_next;
    logic [COORD_BITS-1:0]  row_reg, row_next;
    logic [LEN_BITS-1:0]    length_reg, length_next;

    logic                   out_valid_reg;
    logic [COORD_BITS-1:0]  out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]  out_y_reg, out_y_next;
    logic [LEN_BITS-1:0]    out_length_reg, out_length_next;

    logic                   accept;
    logic                   fg;
    logic                   emit;
    logic [THRESH_BITS-1:0] value_ext;
    logic [LEN_BITS-1:0]    length_inc;

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thresh_reg  <= LOW_THRESH_RESET;
            high_thresh_reg <= HIGH_THRESH_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_LOW_THRESH:  low_thresh_reg  <= cfg_wdata;
                CFG_HIGH_THRESH: high_thresh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // take a pixel whenever the result slot is free or draining
    assign pix_ready = !out_valid_reg || out_ready;
    assign accept    = pix_ctrl.valid && pix_ready;

    // classification; an empty range falls out of the two compares
    assign value_ext = THRESH_BITS'(pix_value);
    assign fg        = (value_ext >= low_thresh_reg) && (value_ext <= high_thresh_reg);

    assign length_inc = (length_reg == LEN_MAX) ? length_reg : length_reg + 1'b1;

    // run tracking
    always_comb begin
        run_open_next   = run_open_reg;
        start_x_next    = start_x_reg;
        row_next        = row_reg;
        length_next     = length_reg;
        emit            = 1'b0;
        out_x_next      = start_x_reg;
        out_y_next      = row_reg;
        out_length_next = length_reg;

        if (accept) begin
            if (fg) begin
                if (run_open_reg) begin
                    length_next = length_inc;
                end else begin
                    start_x_next = pix_x;
                    row_next     = pix_y;
                    length_next  = LEN_BITS'(1);
                end
                run_open_next   = 1'b1;
                out_x_next      = start_x_next;
                out_y_next      = row_next;
                out_length_next = length_next;
                emit            = pix_ctrl.last;
            end else begin
                emit = run_open_reg;
            end

            // a closed run leaves the state cleared
            if (emit) begin
                run_open_next = 1'b0;
                start_x_next  = '0;
                row_next      = '0;
                length_next   = '0;
            end
        end
    end

    // run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg <= 1'b0;
            start_x_reg  <= '0;
            row_reg      <= '0;
            length_reg   <= '0;
        end else begin
            run_open_reg <= run_open_next;
            start_x_reg  <= start_x_next;
            row_reg      <= row_next;
            length_reg   <= length_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_length_reg <= out_length_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_length = out_length_reg;

endmodule

// File: rtl/core/threshold_run_length_encoder.sv
// Channel   Dir  Ports                        Contents
// s_axis    in   s_tvalid/s_tready/s_tdata    pixel value, x, y; s_tlast = segment end
// m_axis    out  m_tvalid/m_tready/m_tdata    run x, run y, run length
// config    in   cfg_wen/cfg_index/cfg_wdata  0: low threshold, 1: high threshold
//
// One pixel per clock sustained while m_tready stays high. A run appears on
// m_tdata once the pixel that closes it has passed the input register and the
// compare and run update have loaded the result register.
// Reset is synchronous, active low; thresholds return to 1 and 65535.
// A stall on m_tready holds the result register and, through ready, the input
// register; while a result waits no pixel moves on, and s_tready drops once the
// input register is also full.
module threshold_run_length_encoder
    import trle_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // pixel stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_BITS-1:0]   s_tdata,   // [15:0] pixel_value, [31:16] pixel_x,
                                               // [47:32] pixel_y
    input  logic                    s_tlast,   // segment_end
    // run stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_BITS-1:0]   m_tdata,   // [15:0] run_x, [31:16] run_y,
                                               // [47:32] run_length
    // threshold writes
    input  logic                    cfg_wen,
    input  cfg_reg_t                cfg_index,
    input  logic [THRESH_BITS-1:0]  cfg_wdata
);

    pix_ctrl_t              pix_ctrl;
    logic                   pix_ready;
    logic [PIXEL_BITS-1:0]  pix_value;
    logic [COORD_BITS-1:0]  pix_x;
    logic [COORD_BITS-1:0]  pix_y;

    logic [COORD_BITS-1:0]  run_x;
    logic [COORD_BITS-1:0]  run_y;
    logic [LEN_BITS-1:0]    run_length;

    // input register; only the used low bits of each field are kept
    trle_in_reg #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[PIXEL_BITS-1:0]),
        .in_x      (s_tdata[FIELD_BITS +: COORD_BITS]),
        .in_y      (s_tdata[2*FIELD_BITS +: COORD_BITS]),
        .in_last   (s_tlast),
        .pix_ctrl  (pix_ctrl),
        .pix_ready (pix_ready),
        .pix_value (pix_value),
        .pix_x     (pix_x),
        .pix_y     (pix_y)
    );

    // thresholds, run state and result register
    trle_run_core #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_run_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pix_ctrl   (pix_ctrl),
        .pix_ready  (pix_ready),
        .pix_value  (pix_value),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (run_x),
        .out_y      (run_y),
        .out_length (run_length)
    );

    // pack the result fields, zero-extended
    assign m_tdata = {FIELD_BITS'(run_length), FIELD_BITS'(run_y), FIELD_BITS'(run_x)};

endmodule
